/* sv/ffd_pkg.sv */
package ffd_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int TAPS_DEFAULT = 32;
   localparam int CIDX_BITS = 5;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_FILTER = 1'b1;

   typedef struct packed {
      logic                          op;
      logic [CIDX_BITS-1:0]          coef_index;
      logic signed [SAMPLE_BITS-1:0] coef_value;
      logic signed [SAMPLE_BITS-1:0] sample;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] filtered;
      logic                          clipped;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic clear;
      logic keep;
      logic last;
   } mac_ctl_type;

endpackage

/* sv/ffd_tap_mem.sv */
module ffd_tap_mem #(
   parameter int DEPTH = ffd_pkg::TAPS_DEFAULT,
   parameter int WIDTH = ffd_pkg::SAMPLE_BITS
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/ffd_mac.sv */
module ffd_mac #(
   parameter int TAPS = ffd_pkg::TAPS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ffd_pkg::mac_ctl_type                  ctl,
   input  logic signed [ffd_pkg::SAMPLE_BITS-1:0] coef,
   input  logic signed [ffd_pkg::SAMPLE_BITS-1:0] samp,
   output logic                                  done,
   output ffd_pkg::rsp_type                      result
);

   localparam int SB = ffd_pkg::SAMPLE_BITS;
   localparam int PW = 2 * SB;
   localparam int ACC_W = PW + $clog2(TAPS);
   localparam int RND_W = ACC_W + 1;
   localparam logic signed [RND_W-1:0] HALF = RND_W'(2 ** (SB - 2));
   localparam logic signed [RND_W-1:0] OUT_MAX = RND_W'(2 ** (SB - 1) - 1);
   localparam logic signed [RND_W-1:0] OUT_MIN = ~OUT_MAX;

   logic signed [PW-1:0]    prod_ff;
   logic                    valid1_ff;
   logic                    clear1_ff;
   logic                    last1_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic                    last2_ff;
   logic                    done_ff;
   ffd_pkg::rsp_type        result_ff;

   logic signed [RND_W-1:0] rnd;
   logic signed [RND_W-1:0] shifted;
   ffd_pkg::rsp_type        result_in;

   always_ff @(posedge clock) begin
      if (ctl.keep) begin
         prod_ff <= coef * samp;
      end else begin
         prod_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         clear1_ff <= 1'b0;
         last1_ff  <= 1'b0;
         last2_ff  <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         valid1_ff <= ctl.valid;
         clear1_ff <= ctl.clear;
         last1_ff  <= ctl.valid && ctl.last;
         last2_ff  <= valid1_ff && last1_ff;
         done_ff   <= last2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (valid1_ff) begin
         if (clear1_ff) begin
            acc_ff <= ACC_W'(prod_ff);
         end else begin
            acc_ff <= acc_ff + ACC_W'(prod_ff);
         end
      end
   end

   always_comb begin
      rnd = RND_W'(acc_ff) + HALF;
      shifted = rnd >>> (SB - 1);
      if (shifted > OUT_MAX) begin
         result_in.filtered = OUT_MAX[SB-1:0];
         result_in.clipped  = 1'b1;
      end else if (shifted < OUT_MIN) begin
         result_in.filtered = OUT_MIN[SB-1:0];
         result_in.clipped  = 1'b1;
      end else begin
         result_in.filtered = shifted[SB-1:0];
         result_in.clipped  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (last2_ff) begin
         result_ff <= result_in;
      end
   end

   assign done = done_ff;
   assign result = result_ff;

endmodule

/* sv/fir_filter_direct_form.sv */
// Direct-form FIR filter, TAPS taps, Q1.15 samples and coefficients.
// Request channel (req_valid/req_ready/req_data): op load writes one
// coefficient and gives no response; coefficient indexes at or beyond
// TAPS are dropped. Op filter shifts one sample into the delay line and
// gives one response on rsp_valid/rsp_ready/rsp_data: the sum of
// products, rounded to Q1.15 and saturated, with clipped set on saturation.
// Delay line and coefficients sit in two single-port-read RAMs; one tap is
// read and multiplied per cycle, and no request is taken while a sum is
// in progress.
// Load every coefficient before the first filter request.
// The response waits in an output register: a new request can be taken
// while it is held. If the receiver still stalls when the next sum is
// ready, the block holds that sum and takes no request until it moves out.
// Reset empties the delay line (history reads as zero) through a fill count;
// the coefficient RAM is not cleared.
module fir_filter_direct_form #(
   parameter int TAPS = ffd_pkg::TAPS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ffd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ffd_pkg::rsp_type rsp_data
);

   localparam int SB = ffd_pkg::SAMPLE_BITS;
   localparam int AW = $clog2(TAPS);
   localparam int FW = $clog2(TAPS + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [AW-1:0]    wptr_ff, wptr_in;
   logic [AW-1:0]    rptr_ff, rptr_in;
   logic [AW-1:0]    tap_ff, tap_in;
   logic [FW-1:0]    fill_ff, fill_in;
   ffd_pkg::mac_ctl_type ctl_ff, ctl_in;
   logic             rsp_valid_ff, rsp_valid_in;
   ffd_pkg::rsp_type rsp_data_ff;

   logic             req_xfer;
   logic             load_xfer;
   logic             filt_xfer;
   logic             coef_ok;
   logic             run;
   logic             rsp_free;
   logic             rsp_load;
   logic [SB-1:0]    coef_rd;
   logic [SB-1:0]    samp_rd;
   logic             mac_done;
   ffd_pkg::rsp_type mac_result;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign load_xfer = req_xfer && (req_data.op == ffd_pkg::OP_LOAD);
   assign filt_xfer = req_xfer && (req_data.op == ffd_pkg::OP_FILTER);
   assign coef_ok   = 32'(req_data.coef_index) < 32'(TAPS);
   assign run       = (state_ff == ST_RUN);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_load  = (state_ff == ST_DONE) && rsp_free;

   ffd_tap_mem #(.DEPTH(TAPS), .WIDTH(SB)) u_coef_mem (
      .clock   (clock),
      .wr_en   (load_xfer && coef_ok),
      .wr_addr (AW'(req_data.coef_index)),
      .wr_data (req_data.coef_value),
      .rd_en   (run),
      .rd_addr (tap_ff),
      .rd_data (coef_rd)
   );

   ffd_tap_mem #(.DEPTH(TAPS), .WIDTH(SB)) u_delay_mem (
      .clock   (clock),
      .wr_en   (filt_xfer),
      .wr_addr (wptr_ff),
      .wr_data (req_data.sample),
      .rd_en   (run),
      .rd_addr (rptr_ff),
      .rd_data (samp_rd)
   );

   ffd_mac #(.TAPS(TAPS)) u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl_ff),
      .coef   ($signed(coef_rd)),
      .samp   ($signed(samp_rd)),
      .done   (mac_done),
      .result (mac_result)
   );

   always_comb begin
      state_in     = state_ff;
      wptr_in      = wptr_ff;
      rptr_in      = rptr_ff;
      tap_in       = tap_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff;
      ctl_in.valid = run;
      ctl_in.clear = (tap_ff == '0);
      ctl_in.keep  = FW'(tap_ff) < fill_ff;
      ctl_in.last  = (tap_ff == AW'(TAPS - 1));

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (filt_xfer) begin
               rptr_in  = wptr_ff;
               wptr_in  = (wptr_ff == AW'(TAPS - 1)) ? '0 : wptr_ff + 1'b1;
               fill_in  = (fill_ff == FW'(TAPS)) ? fill_ff : fill_ff + 1'b1;
               tap_in   = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            tap_in  = tap_ff + 1'b1;
            rptr_in = (rptr_ff == '0) ? AW'(TAPS - 1) : rptr_ff - 1'b1;
            if (tap_ff == AW'(TAPS - 1)) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (mac_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wptr_ff      <= '0;
         rptr_ff      <= '0;
         tap_ff       <= '0;
         fill_ff      <= '0;
         ctl_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wptr_ff      <= wptr_in;
         rptr_ff      <= rptr_in;
         tap_ff       <= tap_in;
         fill_ff      <= fill_in;
         ctl_ff       <= ctl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= mac_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(TAPS))
      else $error("fill count beyond tap count");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> state_ff == ST_WAIT)
      else $error("sum finished outside wait state");

   a_filter_starts: assert property (@(posedge clock) disable iff (reset)
      filt_xfer |=> state_ff == ST_RUN && tap_ff == '0)
      else $error("filter transfer did not start tap sweep");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("response raised without finished sum");
`endif

endmodule
